### rtl/core/wavhc_pkg.sv
// Shared types and constants for the WAV header checker.
`timescale 1ns / 1ps
`default_nettype none

package wavhc_pkg;

  localparam int unsigned RateW  = 31;
  localparam int unsigned PosW   = 6;
  localparam int unsigned FieldW = 32;
  localparam int unsigned HalfW  = 16;

  localparam logic [RateW-1:0]  RateReset  = 31'd20000;
  localparam logic [FieldW-1:0] WaveTag    = 32'h4556_4157;
  localparam logic [HalfW-1:0]  PcmFormat  = 16'd1;
  localparam logic [HalfW-1:0]  MonoChans  = 16'd1;
  localparam logic [HalfW-1:0]  ReqBits    = 16'd16;

  // Byte positions at which a field has just been completed
  localparam logic [PosW-1:0] PosRiffSize = 6'd7;
  localparam logic [PosW-1:0] PosWaveTag  = 6'd11;
  localparam logic [PosW-1:0] PosFormat   = 6'd21;
  localparam logic [PosW-1:0] PosChannels = 6'd23;
  localparam logic [PosW-1:0] PosRate     = 6'd27;
  localparam logic [PosW-1:0] PosByteRate = 6'd31;
  localparam logic [PosW-1:0] PosAlign    = 6'd33;
  localparam logic [PosW-1:0] PosBits     = 6'd35;
  localparam logic [PosW-1:0] PosLast     = 6'd43;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_WAVE  = 3'd1,
    ST_NOT_PCM   = 3'd2,
    ST_NOT_MONO  = 3'd3,
    ST_RATE      = 3'd4,
    ST_BYTE_RATE = 3'd5,
    ST_BITS      = 3'd6
  } status_e;

  typedef struct packed {
    logic              emit;
    status_e           status;
    logic [FieldW-1:0] payload_len;
    logic [FieldW-1:0] riff_len;
    logic [HalfW-1:0]  blk_align;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/wavhc_parse.sv
// Header byte parser: field shift register, position counter and checks.
`timescale 1ns / 1ps
`default_nettype none

module wavhc_parse (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic [7:0]                  byte_i,
  input  wire logic                        start_i,
  input  wire logic [wavhc_pkg::RateW-1:0] rate_i,
  output wavhc_pkg::result_t               res_o
);

  logic [wavhc_pkg::PosW-1:0]   pos_q, pos_d;
  logic [wavhc_pkg::FieldW-1:0] shift_q, shift_d;
  logic                         finished_q, finished_d;
  logic [wavhc_pkg::FieldW-1:0] riff_q, riff_d;
  logic [wavhc_pkg::HalfW-1:0]  align_q, align_d;

  logic                         active;
  logic [wavhc_pkg::PosW-1:0]   pos_cur;
  logic [wavhc_pkg::FieldW-1:0] shift_base;
  logic [wavhc_pkg::HalfW-1:0]  half;
  logic                         emit;
  wavhc_pkg::status_e           status;
  logic [wavhc_pkg::FieldW-1:0] dsize;

  always_comb begin
    active     = accept_i && (start_i || !finished_q);
    pos_cur    = start_i ? '0 : pos_q;
    shift_base = start_i ? '0 : shift_q;
    riff_d     = start_i ? '0 : riff_q;
    align_d    = start_i ? '0 : align_q;
    shift_d    = {byte_i, shift_base[wavhc_pkg::FieldW-1:8]};
    half       = shift_d[wavhc_pkg::FieldW-1:wavhc_pkg::HalfW];
    emit       = 1'b0;
    status     = wavhc_pkg::ST_OK;
    dsize      = '0;

    case (pos_cur)
      wavhc_pkg::PosRiffSize: begin
        riff_d = shift_d;
      end
      wavhc_pkg::PosWaveTag: begin
        if (shift_d != wavhc_pkg::WaveTag) begin
          emit   = 1'b1;
          status = wavhc_pkg::ST_NOT_WAVE;
        end
      end
      wavhc_pkg::PosFormat: begin
        if (half != wavhc_pkg::PcmFormat) begin
          emit   = 1'b1;
          status = wavhc_pkg::ST_NOT_PCM;
        end
      end
      wavhc_pkg::PosChannels: begin
        if (half != wavhc_pkg::MonoChans) begin
          emit   = 1'b1;
          status = wavhc_pkg::ST_NOT_MONO;
        end
      end
      wavhc_pkg::PosRate: begin
        if (shift_d != {1'b0, rate_i}) begin
          emit   = 1'b1;
          status = wavhc_pkg::ST_RATE;
        end
      end
      wavhc_pkg::PosByteRate: begin
        // twice the rate still fits in 32 bits, so no wrap
        if (shift_d != {rate_i, 1'b0}) begin
          emit   = 1'b1;
          status = wavhc_pkg::ST_BYTE_RATE;
        end
      end
      wavhc_pkg::PosAlign: begin
        align_d = half;
      end
      wavhc_pkg::PosBits: begin
        if (half != wavhc_pkg::ReqBits) begin
          emit   = 1'b1;
          status = wavhc_pkg::ST_BITS;
        end
      end
      wavhc_pkg::PosLast: begin
        emit   = 1'b1;
        status = wavhc_pkg::ST_OK;
        dsize  = shift_d;
      end
      default: begin
      end
    endcase

    pos_d      = pos_cur + 1'b1;
    finished_d = emit;

    res_o.emit        = active && emit;
    res_o.status      = status;
    res_o.payload_len = dsize;
    res_o.riff_len    = riff_d;
    res_o.blk_align   = align_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      shift_q    <= '0;
      finished_q <= 1'b1;
      riff_q     <= '0;
      align_q    <= '0;
    end else if (active) begin
      pos_q      <= pos_d;
      shift_q    <= shift_d;
      finished_q <= finished_d;
      riff_q     <= riff_d;
      align_q    <= align_d;
    end
  end

  a_emit_finishes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.emit |=> finished_q)
    else $error("parser did not stop after a result");

  a_ok_at_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.emit && res_o.status == wavhc_pkg::ST_OK && !start_i
      |-> pos_q == wavhc_pkg::PosLast)
    else $error("OK result away from the last header byte");

  a_fail_no_size : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.emit && res_o.status != wavhc_pkg::ST_OK |-> res_o.payload_len == '0)
    else $error("failed header reports a data size");

  a_idle_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q && accept_i && !start_i |=> $stable(pos_q) && finished_q)
    else $error("parser advanced while waiting for a start");

endmodule

`default_nettype wire

### rtl/core/wav_header_checker.sv
// Output: a result word is registered and presented in the cycle after the header byte that causes it.
// Throughput: one header byte per cycle; the input stalls only while a result waits
// in the single output register and the sink holds m_axis_tready low.
// Reset: asynchronous active low; the parser waits for a start byte, the
// expected rate returns to 20000 and the output register is empty.
`timescale 1ns / 1ps
`default_nettype none

module wav_header_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [wavhc_pkg::RateW-1:0] cfg_wdata_i,    // expected_rate
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,   // [7:0] header_byte
  input  wire logic                        s_axis_tuser,   // [0] start_req
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [31:0] payload_len, [63:32] riff_len, [79:64] blk_align
  output logic [79:0]                      m_axis_tdata,
  output logic [2:0]                       m_axis_tuser    // [2:0] status
);

  logic [wavhc_pkg::RateW-1:0] rate_q;
  logic                        accept;
  wavhc_pkg::result_t          res;
  logic                        out_valid_q, out_valid_d;
  logic [79:0]                 out_data_q;
  logic [2:0]                  out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= wavhc_pkg::RateReset;
    end else if (cfg_we_i) begin
      rate_q <= cfg_wdata_i;
    end
  end

  // take a new byte whenever the output register is free or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  wavhc_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .start_i  (s_axis_tuser),
    .rate_i   (rate_q),
    .res_o    (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (res.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.emit) begin
      out_data_q <= {res.blk_align, res.riff_len, res.payload_len};
      out_user_q <= res.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

### dv/wav_header_checker_tb.sv
// Self-checking testbench for the WAV header checker: random header streams against a predictor.
`timescale 1ns / 1ps

module wav_header_checker_tb;
  import wavhc_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldAt     = 200;
  localparam int HoldCycles = 400;

  typedef enum int {SinkOpen, SinkHalf, SinkSparse, SinkToggle} sink_mode_e;

  // Tracks the parse and queues the result word each header should produce
  class header_scoreboard;
    logic [RateW-1:0]  rate;
    logic [PosW-1:0]   pos;
    logic [FieldW-1:0] shift;
    bit                idle;
    logic [FieldW-1:0] riff_size;
    logic [HalfW-1:0]  align;
    result_t           pending[$];
    int                errors;
    int                active_items;

    function new();
      rate         = RateReset;
      pos          = '0;
      shift        = '0;
      idle         = 1'b1;
      riff_size    = '0;
      align        = '0;
      errors       = 0;
      active_items = 0;
    endfunction

    function void set_rate(logic [RateW-1:0] v);
      rate = v;
    endfunction

    function void note_byte(logic [7:0] b, logic st);
      logic [HalfW-1:0] half;
      result_t          r;
      bit               fire;
      if (st) begin
        pos       = '0;
        shift     = '0;
        idle      = 1'b0;
        riff_size = '0;
        align     = '0;
      end else if (idle) begin
        return;
      end
      active_items++;
      shift = {b, shift[FieldW-1:8]};
      half  = shift[FieldW-1:HalfW];
      fire  = 1'b0;
      r     = '0;
      r.status = ST_OK;
      case (pos)
        PosRiffSize: riff_size = shift;
        PosWaveTag: if (shift != WaveTag) begin
          fire = 1'b1; r.status = ST_NOT_WAVE;
        end
        PosFormat: if (half != PcmFormat) begin
          fire = 1'b1; r.status = ST_NOT_PCM;
        end
        PosChannels: if (half != MonoChans) begin
          fire = 1'b1; r.status = ST_NOT_MONO;
        end
        PosRate: if (shift != {1'b0, rate}) begin
          fire = 1'b1; r.status = ST_RATE;
        end
        // compare at 33 bits so twice the rate never wraps
        PosByteRate: if ({1'b0, shift} != {1'b0, rate, 1'b0}) begin
          fire = 1'b1; r.status = ST_BYTE_RATE;
        end
        PosAlign: align = half;
        PosBits: if (half != ReqBits) begin
          fire = 1'b1; r.status = ST_BITS;
        end
        PosLast: begin
          fire = 1'b1;
          r.payload_len = shift;
        end
        default: ;
      endcase
      pos = pos + 1'b1;
      if (fire) begin
        idle        = 1'b1;
        r.emit      = 1'b1;
        r.riff_len  = riff_size;
        r.blk_align = align;
        pending.push_back(r);
      end
    endfunction

    function void check_result(logic [2:0] st, logic [79:0] data);
      result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result word: status %0d data %h", st, data);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        errors++;
      end
      if (data[31:0] !== want.payload_len) begin
        $error("payload_len: expected %h, actual %h", want.payload_len, data[31:0]);
        errors++;
      end
      if (data[63:32] !== want.riff_len) begin
        $error("riff_len: expected %h, actual %h", want.riff_len, data[63:32]);
        errors++;
      end
      if (data[79:64] !== want.blk_align) begin
        $error("blk_align: expected %h, actual %h", want.blk_align, data[79:64]);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [RateW-1:0]  cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;  // [7:0] header_byte
  logic              s_axis_tuser  = 1'b0; // [0] start_req
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // [31:0] payload_len, [63:32] riff_len, [79:64] blk_align
  logic [79:0]       m_axis_tdata;
  logic [2:0]        m_axis_tuser;  // [2:0] status

  header_scoreboard sb = new();
  logic [7:0]       hdr_bytes [0:43];
  int               burst_left = 0;
  int               cycle_count = 0;

  wav_header_checker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sample both handshakes mid-cycle, away from the driving edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tuser);
    end
  end

  function automatic void fill32(int at, logic [31:0] v);
    for (int i = 0; i < 4; i++) hdr_bytes[at + i] = v[8*i +: 8];
  endfunction

  function automatic void fill16(int at, logic [15:0] v);
    hdr_bytes[at]     = v[7:0];
    hdr_bytes[at + 1] = v[15:8];
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Nonzero within the low w bits
  function automatic logic [31:0] flip_mask(int w);
    logic [31:0] one;
    one = 32'd1 << $urandom_range(0, w - 1);
    return $urandom_range(0, 1) ? one : ($urandom | one);
  endfunction

  function automatic int flaw_end(status_e f);
    case (f)
      ST_NOT_WAVE:  return 12;
      ST_NOT_PCM:   return 22;
      ST_NOT_MONO:  return 24;
      ST_RATE:      return 28;
      ST_BYTE_RATE: return 32;
      ST_BITS:      return 36;
      default:      return 44;
    endcase
  endfunction

  function automatic void build_header(logic [RateW-1:0] rate, status_e flaw);
    fill32(0, ($urandom_range(0, 7) == 0) ? $urandom : 32'h4646_4952);
    fill32(4, pick32());
    fill32(8, (flaw == ST_NOT_WAVE) ? WaveTag ^ flip_mask(32) : WaveTag);
    fill32(12, ($urandom_range(0, 7) == 0) ? $urandom : 32'h2074_6d66);
    fill32(16, ($urandom_range(0, 7) == 0) ? $urandom : 32'd16);
    fill16(20, (flaw == ST_NOT_PCM) ? PcmFormat ^ 16'(flip_mask(16)) : PcmFormat);
    fill16(22, (flaw == ST_NOT_MONO) ? MonoChans ^ 16'(flip_mask(16)) : MonoChans);
    fill32(24, (flaw == ST_RATE) ? {1'b0, rate} ^ flip_mask(32) : {1'b0, rate});
    fill32(28, (flaw == ST_BYTE_RATE) ? {rate, 1'b0} ^ flip_mask(32) : {rate, 1'b0});
    fill16(32, 16'(pick32()));
    fill16(34, (flaw == ST_BITS) ? ReqBits ^ 16'(flip_mask(16)) : ReqBits);
    fill32(36, ($urandom_range(0, 7) == 0) ? $urandom : 32'h6174_6164);
    fill32(40, pick32());
  endfunction

  // Offer one word in bursts with random gaps; return at the accepting edge
  task automatic send_word(logic [7:0] b, logic st);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  task automatic send_header(logic [RateW-1:0] rate);
    status_e flaw;
    int      stop_at;
    int      len;
    int      pick;
    flaw = ($urandom_range(0, 4) < 2) ? ST_OK : status_e'($urandom_range(1, 6));
    build_header(rate, flaw);
    stop_at = flaw_end(flaw);
    pick = $urandom_range(0, 19);
    // truncate some headers, run the ignored tail on others
    if (pick < 3) len = $urandom_range(1, stop_at - 1);
    else if (pick < 8) len = 44;
    else len = stop_at;
    for (int i = 0; i < len; i++) send_word(hdr_bytes[i], i == 0);
  endtask

  // Drop valid, drain expected words, then allow for the output latency
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_rate(logic [RateW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    sb.set_rate(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : sink
    sink_mode_e mode;
    int         span;
    int         cnt;
    cnt = 0;
    wait (rst_ni);
    forever begin
      mode = sink_mode_e'($urandom_range(0, 3));
      span = $urandom_range(8, 60);
      repeat (span) begin
        @(posedge clk_i);
        cnt++;
        // hold off long enough for the block to back up its input
        if (cnt == HoldAt) begin
          m_axis_tready <= 1'b0;
          repeat (HoldCycles) @(posedge clk_i);
        end
        case (mode)
          SinkOpen:   m_axis_tready <= 1'b1;
          SinkHalf:   m_axis_tready <= 1'($urandom_range(0, 1));
          SinkSparse: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:    m_axis_tready <= cnt[1];
        endcase
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [RateW-1:0] rates [6];
    int               n;
    rates = '{RateReset, 31'd1, 31'h7FFF_FFFF, 31'd0, 31'd44100,
              31'($urandom_range(32'h7FFF_FFFF, 1))};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bytes before any start are dropped
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    // parse abandoned by a new start
    send_word(8'hFF, 1'b1);
    repeat (3) send_word(8'hFF, 1'b0);
    // bad tag with an all-ones overall size, then ignored tail bytes
    build_header(RateReset, ST_NOT_WAVE);
    fill32(4, '1);
    for (int i = 0; i < 12; i++) send_word(hdr_bytes[i], i == 0);
    send_word(8'h00, 1'b0);
    send_word(8'h5A, 1'b0);

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        settle();
        write_rate(rates[p]);
      end
      while (sb.active_items < (p + 1) * 175) begin
        if ($urandom_range(0, 6) == 0) begin
          n = $urandom_range(1, 8);
          repeat (n) send_word(8'($urandom), $urandom_range(0, 7) == 0);
        end else begin
          send_header(rates[p]);
        end
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
